### src/past_pkg.sv
// past_pkg: shared types and codes for the pending ack sequence table
// depends on nothing; used by past_ctrl, past_dp and pending_ack_sequence_table
package past_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD        = 2'd0;
    localparam logic [1:0] OP_CHECK      = 2'd1;
    localparam logic [1:0] OP_REMOVE_ALL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] seq_num;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, clear scan pointers
        logic scan_step;  // one read / compact step
        logic apply;      // commit count and status
        logic out_load;   // move result into output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_scan;    // captured opcode needs a table scan
        logic scan_done;  // all entries read and written back
    } dp_stat_t;

endpackage

### src/pending_ack_sequence_table.sv
// pending_ack_sequence_table: top level of the pending ack sequence table
// depends on past_pkg, past_ctrl and past_dp
//
//  channel | handshake             | payload             | direction
//  --------+-----------------------+---------------------+----------
//  request | req_valid / req_stall | req (opcode, seq)   | in
//  result  | rsp_valid / rsp_stall | rsp (status, count) | out
//
// one request at a time; add and unused opcodes go from dispatch straight to
// the result, while check and remove-all first scan every stored entry, one
// at a time through the single read port of the entry memory
// reset clears the entry count and all control state; entry memory is not cleared
// a result waits in the output register while rsp_stall is high, and the
// next request is taken meanwhile; it completes once the register frees
module pending_ack_sequence_table
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  past_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output past_pkg::rsp_t  rsp
);

    // command and status between sequencer and datapath
    past_pkg::dp_cmd_t  cmd;
    past_pkg::dp_stat_t stat;

    // sequencer: accept, dispatch, scan, deliver
    past_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: entry memory with in-place compaction, read and write
    // pointers, entry count and the result register
    past_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

### src/past_ctrl.sv
// past_ctrl: sequencing state machine for the pending ack sequence table
// depends on past_pkg
module past_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  past_pkg::dp_stat_t  stat,
    output past_pkg::dp_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_scan)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### src/past_dp.sv
// past_dp: entry memory, scan pointers, count and output register
// depends on past_pkg
module past_dp
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  past_pkg::req_t      req,
    input  past_pkg::dp_cmd_t   cmd,
    output past_pkg::dp_stat_t  stat,
    output past_pkg::rsp_t      rsp
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [7:0]        mem [TABLE_DEPTH];

    past_pkg::req_t    req_reg;
    past_pkg::rsp_t    rsp_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     rd_idx_reg;
    logic [CW-1:0]     wr_idx_reg;
    logic              rd_vld_reg;
    logic [7:0]        rd_data_reg;
    logic              found_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;

    logic              rd_more;
    logic              drop;
    logic              add_ok;
    logic [CW+4:0]     count_ext;

    assign rd_more = (rd_idx_reg < count_reg);
    assign drop    = (rd_data_reg == req_reg.seq_num)
                     && ((req_reg.opcode == past_pkg::OP_REMOVE_ALL) || !found_reg);
    assign add_ok  = (count_reg != CW'(TABLE_DEPTH));

    assign stat.is_scan   = (req_reg.opcode == past_pkg::OP_CHECK)
                            || (req_reg.opcode == past_pkg::OP_REMOVE_ALL);
    assign stat.scan_done = !rd_more && !rd_vld_reg;

    // new count and status once the operation is committed
    always_comb
    begin
        count_next  = count_reg;
        status_next = past_pkg::ST_OK;
        unique case (req_reg.opcode)
            past_pkg::OP_ADD:
            begin
                if (add_ok)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    status_next = past_pkg::ST_FULL;
                end
            end
            past_pkg::OP_CHECK,
            past_pkg::OP_REMOVE_ALL:
            begin
                if (wr_idx_reg == count_reg)
                begin
                    status_next = past_pkg::ST_NOMATCH;
                end
                else
                begin
                    count_next = wr_idx_reg;
                end
            end
            default:
            begin
                status_next = past_pkg::ST_OK;
            end
        endcase
    end

    // count masked to the five bit result field
    assign count_ext = {5'd0, count_reg};

    // entry memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && rd_more)
        begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
        if (cmd.scan_step && rd_vld_reg && !drop)
        begin
            mem[wr_idx_reg[AW-1:0]] <= rd_data_reg;
        end
        else if (cmd.apply && (req_reg.opcode == past_pkg::OP_ADD) && add_ok)
        begin
            mem[count_reg[AW-1:0]] <= req_reg.seq_num;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.apply)
        begin
            status_reg <= status_next;
        end
        if (cmd.out_load)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.entry_count <= count_ext[4:0];
        end
    end

    // scan control and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
                rd_vld_reg <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_vld_reg <= rd_more;
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    if (drop)
                    begin
                        found_reg <= 1'b1;
                    end
                    else
                    begin
                        wr_idx_reg <= wr_idx_reg + CW'(1);
                    end
                end
            end
            if (cmd.apply)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule
